[rtl/bio_pkg.sv]
// ----------------------------------------------------------------------------
// bio_pkg: shared types and constants of the bisection index order block
// Holds the widths, the interval FIFO geometry, the command record passed
// from the front end to the command queue and the engine state encoding.
// ----------------------------------------------------------------------------
package bio_pkg;

   localparam int MAX_COUNT   = 64;
   localparam int COUNT_W     = 7;
   localparam int INDEX_W     = 6;
   localparam int FIFO_DEPTH  = 64;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_FILL_W = FIFO_PTR_W + 1;
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = 1;
   localparam int CMD_CNT_W   = 2;

   typedef struct packed {
      logic [INDEX_W-1:0] hi;
      logic [INDEX_W-1:0] lo;
   } interval_type;

   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_FIRST,
      ENG_SECOND,
      ENG_POP,
      ENG_PROC,
      ENG_PUSH2
   } eng_state_type;

endpackage

[rtl/bio_front.sv]
// ----------------------------------------------------------------------------
// bio_front: command front end
// Accepts an item, saturates its count and drops counts of zero, which
// produce no results, before they reach the command queue.
// ----------------------------------------------------------------------------
module bio_front #(
   parameter int MAX_COUNT = bio_pkg::MAX_COUNT
) (
   input  logic                         start,
   input  logic                         full,
   input  logic [bio_pkg::COUNT_W-1:0]  req_count,
   output logic                         busy,
   output bio_pkg::cmd_type             push
);

   localparam logic [bio_pkg::COUNT_W-1:0] MaxCount = bio_pkg::COUNT_W'(MAX_COUNT);

   logic [bio_pkg::COUNT_W-1:0] sat_count;

   always_comb begin
      sat_count  = (req_count > MaxCount) ? MaxCount : req_count;
      busy       = full;
      // An accepted item with a zero count is consumed here and goes no further.
      push.valid = start && !full && (sat_count != '0);
      push.count = sat_count;
   end

endmodule

[rtl/bio_queue.sv]
// ----------------------------------------------------------------------------
// bio_queue: command queue
// A two-entry queue of saturated counts between the front end and the
// engine, so that a new item can be taken while a run is in progress.
// ----------------------------------------------------------------------------
module bio_queue (
   input  logic              clock,
   input  logic              reset,
   input  bio_pkg::cmd_type  push,
   input  logic              pop,
   output bio_pkg::cmd_type  head,
   output logic              full
);

   logic [bio_pkg::COUNT_W-1:0]   entry_ff [bio_pkg::CMD_DEPTH];
   logic [bio_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bio_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bio_pkg::CMD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          do_push, do_pop;

   always_comb begin
      full       = (cnt_ff == bio_pkg::CMD_CNT_W'(bio_pkg::CMD_DEPTH));
      head.valid = (cnt_ff != '0);
      head.count = entry_ff[rd_ptr_ff];
      do_push    = push.valid && !full;
      do_pop     = pop && head.valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in     = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.count;
      end
   end

endmodule

[rtl/bio_engine.sv]
// ----------------------------------------------------------------------------
// bio_engine: bisection engine
// Runs one count at a time: emits the two end points, then walks the
// inner interval breadth first through an interval FIFO held in memory.
// ----------------------------------------------------------------------------
module bio_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  bio_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   output logic                         rsp_strobe,
   output logic [bio_pkg::INDEX_W-1:0]  rsp_index,
   output logic                         rsp_last
);

   localparam int IW = bio_pkg::INDEX_W;
   localparam int CW = bio_pkg::COUNT_W;
   localparam int PW = bio_pkg::FIFO_PTR_W;
   localparam int FW = bio_pkg::FIFO_FILL_W;

   bio_pkg::eng_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          emitted_ff, emitted_in;
   logic [PW-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]          fill_ff, fill_in;
   bio_pkg::interval_type  push2_ff, push2_in;
   bio_pkg::interval_type  rd_data_ff;
   bio_pkg::interval_type  mem [bio_pkg::FIFO_DEPTH];
   logic                   strobe_ff, strobe_in, last_ff, last_in;
   logic [IW-1:0]          index_ff, index_in;

   logic                   rd_en, wr_en;
   bio_pkg::interval_type  wr_data;
   logic [IW:0]            mid_sum;
   logic [IW-1:0]          mid;
   logic                   at_last;

   assign rsp_strobe = strobe_ff;
   assign rsp_index  = index_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      emitted_in = emitted_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      push2_in   = push2_ff;
      strobe_in  = 1'b0;
      index_in   = index_ff;
      last_in    = 1'b0;
      cmd_pop    = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_data    = push2_ff;
      mid_sum    = {1'b0, rd_data_ff.lo} + {1'b0, rd_data_ff.hi};
      mid        = mid_sum[IW:1];
      at_last    = ({1'b0, emitted_ff} == (count_ff - 1'b1));

      unique case (state_ff)
         bio_pkg::ENG_IDLE: begin
            if (cmd.valid) begin
               cmd_pop    = 1'b1;
               count_in   = cmd.count;
               emitted_in = '0;
               state_in   = bio_pkg::ENG_FIRST;
            end
         end
         bio_pkg::ENG_FIRST: begin
            strobe_in  = 1'b1;
            index_in   = '0;
            last_in    = at_last;
            emitted_in = emitted_ff + 1'b1;
            state_in   = at_last ? bio_pkg::ENG_IDLE : bio_pkg::ENG_SECOND;
         end
         bio_pkg::ENG_SECOND: begin
            strobe_in  = 1'b1;
            index_in   = IW'(count_ff - 1'b1);
            last_in    = at_last;
            emitted_in = emitted_ff + 1'b1;
            if (at_last) begin
               state_in = bio_pkg::ENG_IDLE;
            end else begin
               wr_en      = 1'b1;
               wr_data.lo = IW'(1);
               wr_data.hi = IW'(count_ff - 2'd2);
               state_in   = bio_pkg::ENG_POP;
            end
         end
         bio_pkg::ENG_POP: begin
            if (fill_ff == '0) begin
               state_in = bio_pkg::ENG_IDLE;
            end else begin
               rd_en    = 1'b1;
               head_in  = head_ff + 1'b1;
               fill_in  = fill_ff - 1'b1;
               state_in = bio_pkg::ENG_PROC;
            end
         end
         bio_pkg::ENG_PROC: begin
            strobe_in  = 1'b1;
            last_in    = at_last;
            emitted_in = emitted_ff + 1'b1;
            state_in   = bio_pkg::ENG_POP;
            if (rd_data_ff.lo >= rd_data_ff.hi) begin
               index_in = rd_data_ff.lo;
            end else if ({1'b0, rd_data_ff.lo} + 1'b1 == {1'b0, rd_data_ff.hi}) begin
               // Two-element interval: emit the low end, queue the high end alone.
               index_in   = rd_data_ff.lo;
               wr_en      = 1'b1;
               wr_data.lo = rd_data_ff.hi;
               wr_data.hi = rd_data_ff.hi;
            end else begin
               index_in    = mid;
               wr_en       = 1'b1;
               wr_data.lo  = rd_data_ff.lo;
               wr_data.hi  = mid - 1'b1;
               push2_in.lo = mid + 1'b1;
               push2_in.hi = rd_data_ff.hi;
               state_in    = bio_pkg::ENG_PUSH2;
            end
         end
         bio_pkg::ENG_PUSH2: begin
            wr_en    = 1'b1;
            wr_data  = push2_ff;
            state_in = bio_pkg::ENG_POP;
         end
         default: begin
            state_in = bio_pkg::ENG_IDLE;
         end
      endcase

      // A push onto a full FIFO is dropped.
      if (wr_en && (fill_ff == FW'(bio_pkg::FIFO_DEPTH))) begin
         wr_en = 1'b0;
      end
      if (wr_en) begin
         tail_in = tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bio_pkg::ENG_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      emitted_ff <= emitted_in;
      push2_ff   <= push2_in;
      index_ff   <= index_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

endmodule

[rtl/bisection_index_order_top.sv]
// ----------------------------------------------------------------------------
// bisection_index_order_top: breadth-first bisection index order
// Takes a count n and produces the indices 0..n-1 in coarse-to-fine
// bisection order, one result item per index, the last one flagged.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Handshake
//  --------  -----------------------------  ----------------------------------
//  request   req_count                      taken when start high, busy low
//  response  rsp_index, rsp_last            valid for one cycle on rsp_strobe
//
// An item with count n yields n result items; a count above MAX_COUNT is
// treated as MAX_COUNT and a count of zero yields nothing.
// The engine emits each end point from a state of its own, then passes each
// inner index through a pop and a process state, with a further push state
// when the interval is split in two, because the interval FIFO memory has a
// single write port and a registered read.
// Synchronous reset returns the queue and the engine to idle; the interval
// memory is not cleared, as every entry is written before it is read.
// The receiver cannot stall results; busy rises only when the two-entry
// command queue is full, so an item can be taken while a run is active.
//
module bisection_index_order_top #(
   parameter int MAX_COUNT = bio_pkg::MAX_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bio_pkg::COUNT_W-1:0]  req_count,
   output logic                         rsp_strobe,
   output logic [bio_pkg::INDEX_W-1:0]  rsp_index,
   output logic                         rsp_last
);

   bio_pkg::cmd_type push;
   bio_pkg::cmd_type head;
   logic             full;
   logic             cmd_pop;

   // The front end saturates the count and filters out empty runs.
   bio_front #(
      .MAX_COUNT (MAX_COUNT)
   ) u_front (
      .start     (start),
      .full      (full),
      .req_count (req_count),
      .busy      (busy),
      .push      (push)
   );

   // Commands wait here while the engine finishes the current run.
   bio_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (cmd_pop),
      .head  (head),
      .full  (full)
   );

   // The engine produces one run of indices per command.
   bio_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (head),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_last)
   );

endmodule

[rtl/bio_checker.sv]
// ----------------------------------------------------------------------------
// bio_checker: port-level checks of the bisection index order block
// Watches reset behaviour, the spacing of runs on the result channel and the index that closes a run.
// ----------------------------------------------------------------------------
module bio_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [bio_pkg::INDEX_W-1:0]  rsp_index,
   input logic                         rsp_last
);

   // Reset leaves no result pending.
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_strobe)
      else $error("result strobe seen straight after reset");

   // Reset empties the command queue.
   a_reset_ready: assert property (@(posedge clock) $past(reset) |-> !busy)
      else $error("busy seen straight after reset");

   // The result strobe always drops right after the last item of a run, before a new run starts.
   a_run_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result strobe directly after the last item of a run");

   // Index zero opens every run, so it never closes a longer run; it carries the last
   // flag only when the run held a single item.
   a_zero_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last && $past(rsp_strobe) && !$past(rsp_last))
      |-> (rsp_index != '0))
      else $error("index zero seen as the closing item of a longer run");

endmodule

bind bisection_index_order_top bio_checker u_bio_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_index  (rsp_index),
   .rsp_last   (rsp_last)
);
